FILE: rtl/ksmc_pkg.sv
`timescale 1ns / 1ps
package ksmc_pkg;
  localparam int unsigned MaxFramesDef = 64;
  localparam int unsigned CostWidthDef = 32;
  localparam int unsigned SumWidth     = 48;
  localparam int unsigned CfgWidth     = 7;
  localparam int unsigned IdxWidth     = 6;

  localparam logic [1:0] CfgFrameCount  = 2'd0;
  localparam logic [1:0] CfgSelectCount = 2'd1;
  localparam logic [1:0] CfgMaxLen      = 2'd2;

  localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

  function automatic logic signed [SumWidth-1:0] sat_add(
    input logic signed [SumWidth-1:0] a, input logic signed [SumWidth-1:0] b);
    logic signed [SumWidth:0] s;
    s = {a[SumWidth-1], a} + {b[SumWidth-1], b};
    if (s[SumWidth] != s[SumWidth-1]) begin
      sat_add = s[SumWidth] ? SumMin : SumMax;
    end else begin
      sat_add = s[SumWidth-1:0];
    end
  endfunction
endpackage

FILE: rtl/ksmc_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: q = num / den, 13 by 7 bits.
module ksmc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [12:0] num_i,
  input  logic [6:0]  den_i,
  output logic        done_o,
  output logic [12:0] quo_o
);
  import ksmc_pkg::*;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [12:0] quo_q, quo_d;
  logic [7:0]  rem_q, rem_d;
  logic [6:0]  den_q, den_d;
  logic [8:0]  trial;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    trial = {rem_q, quo_q[12]} - {2'b00, den_q};
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1; cnt_d = 4'd0; quo_d = num_i; rem_d = 8'd0; den_d = den_i;
    end else if (busy_q) begin
      if (!trial[8]) begin
        rem_d = trial[7:0];
        quo_d = {quo_q[11:0], 1'b1};
      end else begin
        rem_d = {rem_q[6:0], quo_q[12]};
        quo_d = {quo_q[11:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd12) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end
  assign quo_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end
endmodule

FILE: rtl/k_step_min_cost_frame_select.sv
`timescale 1ns / 1ps
// Cost entries transfer in at one per cycle, while the block is loading, into an N x N
// cost memory. The entry marked last starts a run: the block stops taking input,
// builds the L candidate frames with a bit-serial divider, then runs the layered
// DP with a single saturating adder and comparator. Each source of a (layer,
// target) pair passes an address state, then a memory read state, and each target
// ends with an address and an accumulate state. Back-trace alternates select and
// predecessor read states, one pick per select state, then the k picks transfer out
// in order, one per cycle unless stalled (or one error result). Input is accepted
// again once the last result has transferred.
module k_step_min_cost_frame_select #(
  parameter int unsigned MAX_FRAMES = ksmc_pkg::MaxFramesDef,
  parameter int unsigned COST_WIDTH = ksmc_pkg::CostWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic signed [31:0] cost_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  frame_index_o,
  output logic [5:0]  position_o,
  output logic        error_o,
  output logic        last_res_o
);
  import ksmc_pkg::*;
  localparam int unsigned NLim = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;
  localparam int unsigned CAW  = $clog2(MAX_FRAMES * MAX_FRAMES);
  localparam int unsigned CW   = (COST_WIDTH < 32) ? COST_WIDTH : 32;
  localparam int unsigned DW   = (COST_WIDTH > 32) ? COST_WIDTH : 32;

  localparam logic [3:0] S_LOAD = 4'd0, S_CHK = 4'd1, S_DIVS = 4'd2,
    S_DIVW = 4'd3, S_INIT = 4'd4, S_ADDR = 4'd5, S_RD = 4'd6, S_ACC = 4'd7,
    S_FIN = 4'd8, S_TRS = 4'd9, S_TRR = 4'd10, S_EMIT = 4'd11, S_ERR = 4'd12;

  logic [3:0] st_q, st_d;
  logic [6:0] fc_q, sc_q, ml_q;
  logic [6:0] n_q, len_q, k_q;
  logic [6:0] s_q, j_q, i_q;

  // cost memory, sign saturated on store
  logic signed [DW-1:0] cmem [MAX_FRAMES*MAX_FRAMES];
  logic signed [DW-1:0] crd_q;
  logic [CAW-1:0] caddr, waddr;
  // candidate frames and DP memories
  logic [5:0] cand [64];
  logic [5:0] cand_i_q, cand_j_q;
  logic signed [SumWidth-1:0] bmem [128];
  logic        bok [128];
  logic signed [SumWidth-1:0] brd_q;
  logic        brd_ok_q;
  logic [5:0]  pmem [4096];
  logic [5:0]  prd_q;
  logic signed [SumWidth-1:0] acc_q;
  logic        acc_ok_q;
  logic [5:0]  accp_q;
  logic [5:0]  cur_q;
  logic [5:0]  pick [64];
  logic        fin_ok_q;
  logic [5:0]  fidx_q;

  logic        div_start, div_done;
  logic [12:0] div_quo;

  ksmc_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(13'(n_q) * 13'(i_q)), .den_i(len_q), .done_o(div_done), .quo_o(div_quo)
  );

  logic in_fire, out_fire;
  assign in_stall_o = (st_q != S_LOAD);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_valid_o = (st_q == S_EMIT) || (st_q == S_ERR);
  assign out_fire   = out_valid_o && !out_stall_i;
  assign frame_index_o = (st_q == S_EMIT) ? fidx_q : 6'd0;
  assign position_o    = (st_q == S_EMIT) ? i_q[5:0] : 6'd0;
  assign error_o       = (st_q == S_ERR);
  assign last_res_o    = (st_q == S_ERR) || (i_q == k_q - 7'd1);

  logic signed [SumWidth-1:0] sum;
  assign sum = sat_add(brd_q, SumWidth'(crd_q));
  logic pl, nl;
  assign nl = s_q[0];
  assign pl = ~s_q[0];

  logic [6:0] n_sat, len_c;
  always_comb begin
    n_sat = (fc_q > 7'(NLim)) ? 7'(NLim) : fc_q;
    len_c = (n_sat < ml_q) ? n_sat : ml_q;
    if (sc_q > ml_q) len_c = sc_q;
  end

  logic signed [DW-1:0] cost_sat;
  always_comb begin
    cost_sat = DW'(cost_i);
    if (CW < 32) begin
      if (cost_i > $signed(33'((64'd1 << (CW-1)) - 1)))
        cost_sat = DW'($signed(33'((64'd1 << (CW-1)) - 1)));
      else if (cost_i < -$signed(33'(64'd1 << (CW-1))))
        cost_sat = DW'(-$signed(33'(64'd1 << (CW-1))));
    end
  end

  // row-major cost address
  assign caddr = CAW'(cand_i_q) * CAW'(MAX_FRAMES) + CAW'(cand_j_q);
  assign waddr = CAW'(row_i) * CAW'(MAX_FRAMES) + CAW'(col_i);
  assign div_start = (st_q == S_DIVS);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_LOAD: if (in_fire && last_i) st_d = S_CHK;
      S_CHK: begin
        if (n_sat == 0 || sc_q == 0 || sc_q > n_sat || len_c > 7'(NLim))
          st_d = S_ERR;
        else st_d = S_DIVS;
      end
      S_DIVS: st_d = S_DIVW;
      S_DIVW: if (div_done) st_d = (i_q == len_q - 7'd1) ? S_INIT : S_DIVS;
      S_INIT: st_d = (k_q == 7'd1) ? S_FIN : S_ADDR;
      S_ADDR: st_d = (i_q >= j_q) ? S_ACC : S_RD;
      S_RD:   st_d = S_ADDR;
      S_ACC: begin
        if (j_q == len_q - 7'd1) st_d = (s_q == k_q) ? S_FIN : S_ADDR;
        else st_d = S_ADDR;
      end
      S_FIN:  st_d = fin_ok_q ? S_TRS : S_ERR;
      S_TRS:  st_d = (s_q < 7'd2) ? S_EMIT : S_TRR;
      S_TRR:  st_d = S_TRS;
      S_EMIT: if (out_fire && i_q == k_q - 7'd1) st_d = S_LOAD;
      S_ERR:  if (out_fire) st_d = S_LOAD;
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; fc_q <= 7'd64; sc_q <= 7'd8; ml_q <= 7'd64;
      s_q <= '0; j_q <= '0; i_q <= '0; cur_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgFrameCount:  fc_q <= cfg_data_i;
          CfgSelectCount: sc_q <= cfg_data_i;
          CfgMaxLen:      ml_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (st_q)
        S_CHK: i_q <= '0;
        S_DIVW: if (div_done) i_q <= i_q + 7'd1;
        S_INIT: begin s_q <= 7'd2; j_q <= '0; i_q <= '0; end
        S_ACC: begin
          i_q <= '0;
          if (j_q == len_q - 7'd1) begin j_q <= '0; s_q <= s_q + 7'd1; end
          else j_q <= j_q + 7'd1;
        end
        S_RD: i_q <= i_q + 7'd1;
        S_FIN: begin s_q <= k_q; cur_q <= len_q[5:0] - 6'd1; i_q <= '0; end
        S_TRS: ;
        S_TRR: begin s_q <= s_q - 7'd1; cur_q <= prd_q; end
        S_EMIT: if (out_fire) i_q <= i_q + 7'd1;
        default: ;
      endcase
    end
  end

  // datapath and memories
  always_ff @(posedge clk_i) begin
    if (in_fire && (32'(row_i) < MAX_FRAMES) && (32'(col_i) < MAX_FRAMES))
      cmem[waddr] <= cost_sat;
    if (st_q == S_CHK) begin n_q <= n_sat; len_q <= len_c; k_q <= sc_q; end
    if (st_q == S_DIVW && div_done) cand[i_q[5:0]] <= div_quo[5:0];
    if (st_q == S_INIT) begin
      acc_ok_q <= 1'b0;
      // a single pick has a path only when there is a single candidate
      fin_ok_q <= (len_q == 7'd1);
    end
    // address stage: fetch candidate frames for the cost address and prior layer sum for source i
    if (st_q == S_ADDR) begin
      cand_i_q <= cand[i_q[5:0]];
      cand_j_q <= cand[j_q[5:0]];
      // layer 1 holds only candidate 0, at sum zero
      brd_q    <= (s_q == 7'd2) ? '0 : bmem[{pl, i_q[5:0]}];
      brd_ok_q <= ((s_q == 7'd2) ? (i_q == 7'd0) : bok[{pl, i_q[5:0]}]) && (i_q < j_q);
    end
    if (st_q == S_RD) crd_q <= cmem[caddr];
    // compare stage runs on the previous read (folded into next ADDR)
    if (st_q == S_ADDR && i_q != 0 && brd_ok_q && (!acc_ok_q || sum < acc_q)) begin
      acc_q <= sum; acc_ok_q <= 1'b1; accp_q <= i_q[5:0] - 6'd1;
    end
    if (st_q == S_ACC) begin
      bmem[{nl, j_q[5:0]}] <= acc_q;
      bok[{nl, j_q[5:0]}]  <= acc_ok_q;
      pmem[{j_q[5:0], s_q[5:0]}] <= accp_q;
      acc_ok_q <= 1'b0;
      if (j_q == len_q - 7'd1 && s_q == k_q) fin_ok_q <= acc_ok_q;
    end
    if (st_q == S_TRS) begin
      pick[s_q[5:0] - 6'd1] <= cand[cur_q];
      prd_q <= pmem[{cur_q, s_q[5:0]}];
      if (s_q < 7'd2) fidx_q <= cand[cur_q];
    end
    // hold the pick under stall, advance on transfer
    if (st_q == S_EMIT && out_fire && i_q != k_q - 7'd1)
      fidx_q <= pick[i_q[5:0] + 6'd1];
  end
endmodule
